// ===== design/tksd_pkg.sv =====
// Shared types and constants for the terminal key sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package tksd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] B_ESC   = 8'h1B;
  localparam logic [7:0] B_DEL   = 8'd127;
  localparam logic [7:0] B_BS    = 8'd8;
  localparam logic [7:0] B_CR    = 8'h0D;
  localparam logic [7:0] B_LF    = 8'h0A;
  localparam logic [7:0] B_TAB   = 8'h09;
  localparam logic [7:0] B_SPACE = 8'h20;
  localparam logic [7:0] B_LBRK  = 8'h5B;
  localparam logic [7:0] B_O     = 8'h4F;
  localparam logic [7:0] B_TILDE = 8'h7E;
  localparam logic [7:0] B_SEMI  = 8'h3B;
  localparam logic [7:0] B_UA    = 8'h41;
  localparam logic [7:0] B_UB    = 8'h42;
  localparam logic [7:0] B_UC    = 8'h43;
  localparam logic [7:0] B_UD    = 8'h44;
  localparam logic [7:0] B_UF    = 8'h46;
  localparam logic [7:0] B_UH    = 8'h48;
  localparam logic [7:0] B_UP    = 8'h50;
  localparam logic [7:0] B_UQ    = 8'h51;
  localparam logic [7:0] B_UR    = 8'h52;
  localparam logic [7:0] B_US    = 8'h53;
  localparam logic [7:0] B_D1    = 8'h31;
  localparam logic [7:0] B_D2    = 8'h32;
  localparam logic [7:0] B_D3    = 8'h33;
  localparam logic [7:0] B_D4    = 8'h34;
  localparam logic [7:0] B_D5    = 8'h35;
  localparam logic [7:0] B_D6    = 8'h36;

  localparam logic [4:0] K_UNKNOWN   = 5'd0;
  localparam logic [4:0] K_CHAR      = 5'd1;
  localparam logic [4:0] K_ENTER     = 5'd2;
  localparam logic [4:0] K_TAB       = 5'd3;
  localparam logic [4:0] K_BACKSPACE = 5'd4;
  localparam logic [4:0] K_SPACE     = 5'd5;
  localparam logic [4:0] K_UP        = 5'd6;
  localparam logic [4:0] K_DOWN      = 5'd7;
  localparam logic [4:0] K_RIGHT     = 5'd8;
  localparam logic [4:0] K_LEFT      = 5'd9;
  localparam logic [4:0] K_HOME      = 5'd10;
  localparam logic [4:0] K_END       = 5'd11;
  localparam logic [4:0] K_PGUP      = 5'd12;
  localparam logic [4:0] K_PGDN      = 5'd13;
  localparam logic [4:0] K_INSERT    = 5'd14;
  localparam logic [4:0] K_DELETE    = 5'd15;
  localparam logic [4:0] K_F1        = 5'd16;
  localparam logic [4:0] K_F2        = 5'd17;

  typedef enum logic [4:0] {
    CLS_GAP, CLS_ESC, CLS_LBRK, CLS_O,
    CLS_A, CLS_B, CLS_C, CLS_D, CLS_F, CLS_H,
    CLS_P, CLS_Q, CLS_R, CLS_S,
    CLS_TILDE, CLS_SEMI,
    CLS_1, CLS_2, CLS_3, CLS_4, CLS_5, CLS_6,
    CLS_ENTER, CLS_TAB, CLS_BKSP, CLS_SPACE, CLS_OTHER
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
  } queue_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== design/terminal_key_sequence_decoder.sv =====
// Top level of the terminal key sequence decoder.
//
// Input stream (s_axis_*): one transaction per received byte or gap marker.
//   tdata carries the byte, tuser is high for a gap (no byte, tdata ignored).
// Output stream (m_axis_*): one transaction per decoded key event.
//   tdata carries the key code, the F3/F4 flag and the character value.
// A front stage classifies each byte and writes it into a small queue; the
// sequence state machine drains the queue into the output register.
// A byte that ends a key event is written into the queue and then popped into
//   the output register, from which it shows on m_axis.
// Throughput: one input transaction per cycle while the queue is not full, set
//   by the state machine step that reads one queue entry a cycle when not stalled.
// Bytes that open or continue a sequence, and gaps while idle, give no output.
// When m_axis_tready is low the output register holds its event, the queue
//   fills, and s_axis_tready drops once the queue is full.
// Reset clears the queue, the output valid and the parse state to idle; the
//   block accepts input in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module terminal_key_sequence_decoder
  import tksd_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tuser,   // [0] op (gap)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [4:0] key_code, [5] key_f_high,
                                           // [13:6] char_value, [15:14] zero
);

  logic          push;
  logic          pop;
  queue_entry_t  push_entry;
  queue_entry_t  pop_entry;
  queue_status_t q_status;

  tksd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status      (q_status),
    .push          (push),
    .push_entry    (push_entry)
  );

  tksd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_status   (q_status)
  );

  tksd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== design/tksd_front.sv =====
// Input side: accepts bytes and gap markers and tags each with its byte class.
`timescale 1ns / 1ps
`default_nettype none

module tksd_front
  import tksd_pkg::*;
(
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,
  input  wire logic          s_axis_tuser,
  input  wire queue_status_t q_status,
  output logic               push,
  output queue_entry_t       push_entry
);

  byte_class_t cls;

  always_comb begin
    if (s_axis_tuser) begin
      cls = CLS_GAP;
    end else begin
      unique case (s_axis_tdata)
        B_ESC:        cls = CLS_ESC;
        B_LBRK:       cls = CLS_LBRK;
        B_O:          cls = CLS_O;
        B_UA:         cls = CLS_A;
        B_UB:         cls = CLS_B;
        B_UC:         cls = CLS_C;
        B_UD:         cls = CLS_D;
        B_UF:         cls = CLS_F;
        B_UH:         cls = CLS_H;
        B_UP:         cls = CLS_P;
        B_UQ:         cls = CLS_Q;
        B_UR:         cls = CLS_R;
        B_US:         cls = CLS_S;
        B_TILDE:      cls = CLS_TILDE;
        B_SEMI:       cls = CLS_SEMI;
        B_D1:         cls = CLS_1;
        B_D2:         cls = CLS_2;
        B_D3:         cls = CLS_3;
        B_D4:         cls = CLS_4;
        B_D5:         cls = CLS_5;
        B_D6:         cls = CLS_6;
        B_CR, B_LF:   cls = CLS_ENTER;
        B_TAB:        cls = CLS_TAB;
        B_DEL, B_BS:  cls = CLS_BKSP;
        B_SPACE:      cls = CLS_SPACE;
        default:      cls = CLS_OTHER;
      endcase
    end
  end

  assign s_axis_tready   = !q_status.full;
  assign push            = s_axis_tvalid && !q_status.full;
  assign push_entry.cls  = cls;
  assign push_entry.data = s_axis_tdata;

endmodule

`default_nettype wire

// ===== design/tksd_queue.sv =====
// Small FIFO of classified bytes between the front and the sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

module tksd_queue
  import tksd_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire queue_entry_t  push_entry,
  input  wire logic          pop,
  output queue_entry_t       pop_entry,
  output queue_status_t      q_status
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(Depth);

  queue_entry_t  mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_entry      = mem[rd_ptr];
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == FULL_COUNT);

endmodule

`default_nettype wire

// ===== design/tksd_back.sv =====
// Escape sequence state machine with registered key event output.
`timescale 1ns / 1ps
`default_nettype none

module tksd_back
  import tksd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire queue_status_t q_status,
  input  wire queue_entry_t  pop_entry,
  output logic               pop,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [15:0]        m_axis_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_ESC, S_CSI, S_SS3, S_TILDE,
    S_CSI1, S_CSI1_SEMI, S_CSI4, S_CSI4_SEMI
  } state_t;

  state_t      state, state_next;
  logic [4:0]  pending_key, pending_key_next;
  logic [4:0]  key_code;
  logic        key_f_high;
  logic [7:0]  char_value;

  logic        emit;
  logic [4:0]  code;
  logic        fhigh;
  logic [7:0]  ch;
  byte_class_t cls;

  function automatic logic [4:0] arrow_key(byte_class_t c);
    unique case (c)
      CLS_A:   return K_UP;
      CLS_B:   return K_DOWN;
      CLS_C:   return K_RIGHT;
      CLS_D:   return K_LEFT;
      CLS_H:   return K_HOME;
      CLS_F:   return K_END;
      default: return K_UNKNOWN;
    endcase
  endfunction

  assign cls = pop_entry.cls;
  assign pop = !q_status.empty && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    emit             = 1'b0;
    code             = K_UNKNOWN;
    fhigh            = 1'b0;
    ch               = 8'd0;
    state_next       = S_IDLE;
    pending_key_next = pending_key;
    if (state == S_IDLE) begin
      unique case (cls)
        CLS_GAP: ;
        CLS_ESC: begin
          state_next       = S_ESC;
          pending_key_next = K_UNKNOWN;
        end
        CLS_ENTER: begin emit = 1'b1; code = K_ENTER; end
        CLS_TAB:   begin emit = 1'b1; code = K_TAB; end
        CLS_BKSP:  begin emit = 1'b1; code = K_BACKSPACE; end
        CLS_SPACE: begin emit = 1'b1; code = K_SPACE; end
        default: begin
          emit = 1'b1;
          code = K_CHAR;
          ch   = pop_entry.data;
        end
      endcase
    end else begin
      // anything not matched below closes the sequence as unknown
      emit = 1'b1;
      unique case (state)
        S_ESC: begin
          unique case (cls)
            CLS_LBRK: begin emit = 1'b0; state_next = S_CSI; pending_key_next = K_UNKNOWN; end
            CLS_O:    begin emit = 1'b0; state_next = S_SS3; pending_key_next = K_UNKNOWN; end
            default: ;
          endcase
        end
        S_CSI: begin
          unique case (cls) inside
            CLS_A, CLS_B, CLS_C, CLS_D, CLS_H, CLS_F: code = arrow_key(cls);
            CLS_5: begin emit = 1'b0; state_next = S_TILDE; pending_key_next = K_PGUP; end
            CLS_6: begin emit = 1'b0; state_next = S_TILDE; pending_key_next = K_PGDN; end
            CLS_2: begin emit = 1'b0; state_next = S_TILDE; pending_key_next = K_INSERT; end
            CLS_3: begin emit = 1'b0; state_next = S_TILDE; pending_key_next = K_DELETE; end
            CLS_1: begin emit = 1'b0; state_next = S_CSI1; pending_key_next = K_UNKNOWN; end
            CLS_4: begin emit = 1'b0; state_next = S_CSI4; pending_key_next = K_UNKNOWN; end
            default: ;
          endcase
        end
        S_SS3: begin
          unique case (cls) inside
            CLS_A, CLS_B, CLS_C, CLS_D, CLS_H, CLS_F: code = arrow_key(cls);
            CLS_P: code = K_F1;
            CLS_Q: code = K_F2;
            CLS_R: begin code = K_F1; fhigh = 1'b1; end
            CLS_S: begin code = K_F2; fhigh = 1'b1; end
            default: ;
          endcase
        end
        S_TILDE: begin
          if (cls == CLS_TILDE) begin
            code = pending_key;
          end
        end
        S_CSI1: begin
          unique case (cls)
            CLS_TILDE: code = K_HOME;
            CLS_SEMI: begin emit = 1'b0; state_next = S_CSI1_SEMI; pending_key_next = K_UNKNOWN; end
            default: ;
          endcase
        end
        S_CSI1_SEMI: begin
          unique case (cls)
            CLS_5: begin emit = 1'b0; state_next = S_TILDE; pending_key_next = K_PGUP; end
            CLS_6: begin emit = 1'b0; state_next = S_TILDE; pending_key_next = K_PGDN; end
            default: ;
          endcase
        end
        S_CSI4: begin
          unique case (cls)
            CLS_TILDE: code = K_END;
            CLS_SEMI: begin emit = 1'b0; state_next = S_CSI4_SEMI; pending_key_next = K_UNKNOWN; end
            default: ;
          endcase
        end
        S_CSI4_SEMI: begin
          if (cls == CLS_1) begin
            emit             = 1'b0;
            state_next       = S_TILDE;
            pending_key_next = K_END;
          end
        end
        default: ;
      endcase
      // a gap inside a sequence always ends it as unknown
      if (cls == CLS_GAP) begin
        emit             = 1'b1;
        code             = K_UNKNOWN;
        fhigh            = 1'b0;
        state_next       = S_IDLE;
        pending_key_next = pending_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pending_key   <= K_UNKNOWN;
      m_axis_tvalid <= 1'b0;
      key_code      <= K_UNKNOWN;
      key_f_high    <= 1'b0;
      char_value    <= 8'd0;
    end else if (pop) begin
      state         <= state_next;
      pending_key   <= pending_key_next;
      m_axis_tvalid <= emit;
      if (emit) begin
        key_code   <= code;
        key_f_high <= fhigh;
        char_value <= ch;
      end
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {2'b00, char_value, key_f_high, key_code};

endmodule

`default_nettype wire

// ===== design/tksd_checker.sv =====
// Port-level checker for the terminal key sequence decoder, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module tksd_checker
  import tksd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output event changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[4:0] <= K_F2 && m_axis_tdata[15:14] == 2'b00)
    else $error("key code out of range");

  a_char_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4:0] != K_CHAR |-> m_axis_tdata[13:6] == 8'd0)
    else $error("character value on a non-character event");

  a_fhigh_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4:0] == K_F1 || m_axis_tdata[4:0] == K_F2)
    else $error("F3/F4 flag on a non-function key");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the terminal key sequence decoder.
`timescale 1ns / 1ps

module tb;
  import tksd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ESC, ST_CSI, ST_SS3, ST_TILDE,
    ST_CSI1, ST_CSI1_SEMI, ST_CSI4, ST_CSI4_SEMI
  } seq_state_t;

  typedef struct packed {
    logic [4:0] code;
    logic       f_high;
    logic [7:0] ch;
  } key_event_t;

  class key_event_board;
    seq_state_t state;
    logic [4:0] tilde_key;
    key_event_t expected_q[$];
    int         errors;

    function new();
      state = ST_IDLE;
      tilde_key = K_UNKNOWN;
      errors = 0;
    endfunction

    function bit nav_code(input logic [7:0] b, output logic [4:0] k);
      nav_code = 1'b1;
      case (b)
        B_UA: k = K_UP;
        B_UB: k = K_DOWN;
        B_UC: k = K_RIGHT;
        B_UD: k = K_LEFT;
        B_UH: k = K_HOME;
        B_UF: k = K_END;
        default: begin
          k = K_UNKNOWN;
          nav_code = 1'b0;
        end
      endcase
    endfunction

    // Advance the parser by one transaction and queue the key event it yields.
    function void note_input(input logic gap, input logic [7:0] b);
      key_event_t ev;
      seq_state_t nxt;
      logic [4:0] k;
      bit         hit;
      ev = '0;
      nxt = ST_IDLE;
      hit = 1'b1;
      if (state == ST_IDLE) begin
        if (gap) begin
          hit = 1'b0;
        end else if (b == B_ESC) begin
          nxt = ST_ESC;
          hit = 1'b0;
        end else if (b == B_CR || b == B_LF) begin
          ev.code = K_ENTER;
        end else if (b == B_TAB) begin
          ev.code = K_TAB;
        end else if (b == B_DEL || b == B_BS) begin
          ev.code = K_BACKSPACE;
        end else if (b == B_SPACE) begin
          ev.code = K_SPACE;
        end else begin
          ev.code = K_CHAR;
          ev.ch = b;
        end
      end else if (!gap) begin
        ev.code = K_UNKNOWN;
        case (state)
          ST_ESC: begin
            if (b == B_LBRK) nxt = ST_CSI;
            else if (b == B_O) nxt = ST_SS3;
          end
          ST_CSI: begin
            if (nav_code(b, k)) ev.code = k;
            else if (b == B_D5) begin nxt = ST_TILDE; tilde_key = K_PGUP; end
            else if (b == B_D6) begin nxt = ST_TILDE; tilde_key = K_PGDN; end
            else if (b == B_D2) begin nxt = ST_TILDE; tilde_key = K_INSERT; end
            else if (b == B_D3) begin nxt = ST_TILDE; tilde_key = K_DELETE; end
            else if (b == B_D1) nxt = ST_CSI1;
            else if (b == B_D4) nxt = ST_CSI4;
          end
          ST_SS3: begin
            if (nav_code(b, k)) ev.code = k;
            else if (b == B_UP) ev.code = K_F1;
            else if (b == B_UQ) ev.code = K_F2;
            else if (b == B_UR) begin ev.code = K_F1; ev.f_high = 1'b1; end
            else if (b == B_US) begin ev.code = K_F2; ev.f_high = 1'b1; end
          end
          ST_TILDE: begin
            if (b == B_TILDE) ev.code = tilde_key;
          end
          ST_CSI1: begin
            if (b == B_TILDE) ev.code = K_HOME;
            else if (b == B_SEMI) nxt = ST_CSI1_SEMI;
          end
          ST_CSI1_SEMI: begin
            if (b == B_D5) begin nxt = ST_TILDE; tilde_key = K_PGUP; end
            else if (b == B_D6) begin nxt = ST_TILDE; tilde_key = K_PGDN; end
          end
          ST_CSI4: begin
            if (b == B_TILDE) ev.code = K_END;
            else if (b == B_SEMI) nxt = ST_CSI4_SEMI;
          end
          ST_CSI4_SEMI: begin
            if (b == B_D1) begin nxt = ST_TILDE; tilde_key = K_END; end
          end
          default: ;
        endcase
        hit = (nxt == ST_IDLE);
      end
      state = nxt;
      if (hit) expected_q.push_back(ev);
    endfunction

    function void check_event(input logic [15:0] data);
      key_event_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected key event tdata=%h", data);
        return;
      end
      want = expected_q.pop_front();
      if (data[4:0] !== want.code || data[5] !== want.f_high ||
          data[13:6] !== want.ch || data[15:14] !== 2'b00) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected code %0d fhigh %0d char %02h, ",
                    "got code %0d fhigh %0d char %02h pad %0d"},
                   want.code, want.f_high, want.ch, data[4:0], data[5], data[13:6],
                   data[15:14]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;   // [0] op (gap)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [4:0] key_code, [5] key_f_high, [13:6] char_value

  terminal_key_sequence_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  key_event_board board = new();

  localparam int RANDOM_ITEMS = 450;
  localparam int DIR_N = 25;

  logic [8:0] directed [DIR_N] = '{
    {1'b1, 8'hA5}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b0, B_CR},
    {1'b0, B_ESC}, {1'b0, B_LBRK}, {1'b0, B_D1}, {1'b0, B_SEMI}, {1'b0, B_D5},
    {1'b0, B_TILDE},
    {1'b0, B_ESC}, {1'b0, B_LBRK}, {1'b0, B_D4}, {1'b0, B_SEMI}, {1'b0, B_D1},
    {1'b0, B_TILDE},
    {1'b0, B_ESC}, {1'b0, B_O}, {1'b0, B_UR},
    {1'b0, B_ESC}, {1'b0, B_ESC},
    {1'b0, B_ESC}, {1'b0, B_LBRK}, {1'b1, 8'h5A}
  };

  logic [7:0] nav_bytes [10] = '{B_UA, B_UB, B_UC, B_UD, B_UH, B_UF, B_UP, B_UQ, B_UR, B_US};
  logic [7:0] tilde_digits [4] = '{B_D5, B_D6, B_D2, B_D3};
  logic [7:0] single_keys [6] = '{B_CR, B_LF, B_TAB, B_DEL, B_BS, B_SPACE};

  logic [8:0] stroke[$];
  int         items_sent = 0;
  int         burst_left = 1;

  initial forever #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_event(m_axis_tdata);
  end

  // Receiver: alternating stretches of full rate, random, long stall and light stall.
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 40);
      for (int i = 0; i < len; i++) begin
        @(posedge clk);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= (i == len - 1);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic gap, input logic [7:0] b);
    int pause;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= gap;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(gap, b);
    items_sent++;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      pause = $urandom_range(0, 8);
      if (pause > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic add_escape(input int kind);
    stroke.push_back({1'b0, B_ESC});
    if (kind < 6) begin
      stroke.push_back({1'b0, B_LBRK});
      stroke.push_back({1'b0, nav_bytes[kind]});
    end else if (kind < 16) begin
      stroke.push_back({1'b0, B_O});
      stroke.push_back({1'b0, nav_bytes[kind - 6]});
    end else if (kind < 20) begin
      stroke.push_back({1'b0, B_LBRK});
      stroke.push_back({1'b0, tilde_digits[kind - 16]});
      stroke.push_back({1'b0, B_TILDE});
    end else begin
      stroke.push_back({1'b0, B_LBRK});
      case (kind)
        20: stroke.push_back({1'b0, B_D1});
        21: begin
          stroke.push_back({1'b0, B_D1});
          stroke.push_back({1'b0, B_SEMI});
          stroke.push_back({1'b0, B_D5});
        end
        22: begin
          stroke.push_back({1'b0, B_D1});
          stroke.push_back({1'b0, B_SEMI});
          stroke.push_back({1'b0, B_D6});
        end
        23: stroke.push_back({1'b0, B_D4});
        default: begin
          stroke.push_back({1'b0, B_D4});
          stroke.push_back({1'b0, B_SEMI});
          stroke.push_back({1'b0, B_D1});
        end
      endcase
      stroke.push_back({1'b0, B_TILDE});
    end
  endtask

  function automatic logic [8:0] noise_item();
    if ($urandom_range(0, 3) == 0) return {1'b1, 8'($urandom_range(0, 255))};
    return {1'b0, 8'($urandom_range(0, 255))};
  endfunction

  // Mostly complete key strokes, with some stray bytes and cut-off sequences.
  task automatic build_stroke();
    int pick;
    int cut;
    int k;
    stroke.delete();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      add_escape($urandom_range(0, 24));
    end else if (pick < 70) begin
      k = $urandom_range(0, 6);
      if (k < 6) stroke.push_back({1'b0, single_keys[k]});
      else stroke.push_back({1'b0, 8'($urandom_range(0, 255))});
    end else if (pick < 85) begin
      stroke.push_back(noise_item());
    end else begin
      add_escape($urandom_range(0, 24));
      cut = $urandom_range(1, stroke.size() - 1);
      while (stroke.size() > cut) void'(stroke.pop_back());
      stroke.push_back(noise_item());
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i][8], directed[i][7:0]);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!held && items_sent >= RANDOM_ITEMS / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        held = 1'b1;
      end
      build_stroke();
      foreach (stroke[i]) send_item(stroke[i][8], stroke[i][7:0]);
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tksd_pkg.sv
design/tksd_front.sv
design/tksd_queue.sv
design/tksd_back.sv
design/terminal_key_sequence_decoder.sv
design/tksd_checker.sv
dv/tb.sv
